[rtl/assert_macros.svh]
// assertion macros included by quaternion_vector_rotate_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define QVR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("qvr assertion failed");

// checked at every edge, reset included
`define QVR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("qvr assertion failed");

`endif

[rtl/qvr_pkg.sv]
// types and constants of the quaternion vector rotate block
package qvr_pkg;

  localparam int VEC_WIDTH  = 16;
  localparam int ROT_WIDTH  = 16;
  localparam int FRAC_SHIFT = 28;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROT_W = 2'd0,
    REG_ROT_X = 2'd1,
    REG_ROT_Y = 2'd2,
    REG_ROT_Z = 2'd3
  } cfg_reg_t;

  localparam logic signed [ROT_WIDTH-1:0] ROT_W_RESET = 16'sd16384;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] vec_x;
    logic signed [VEC_WIDTH-1:0] vec_y;
    logic signed [VEC_WIDTH-1:0] vec_z;
    logic signed [VEC_WIDTH-1:0] vec_w;
  } vec_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic signed [VEC_WIDTH-1:0] out_w;
  } res_t;

endpackage

[rtl/quaternion_vector_rotate_top.sv]
// Quaternion vector rotation r = q * (0, v) * conj(q), five register stages.
// Takes one vector per clock while vec_stall is low and passes it through
// the stages in order: two multiply stages (quaternion by vector, then the
// intermediate quaternion by the conjugate) each followed by an add stage,
// then a floor-and-saturate output register. The quaternion comes from four
// signed Q1.14 registers written through cfg_wr_en / cfg_index / cfg_data
// (rot_w, rot_x, rot_y, rot_z, reset to identity); write them only while the
// pipeline is empty. The sums are exact, shifted right by 28 toward minus
// infinity and saturated to 16 bits; vec_w is carried through as out_w.
// A stall on the result side fills empty stages before vec_stall rises.
module quaternion_vector_rotate_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vec_valid,
  output logic                                vec_stall,
  input  qvr_pkg::vec_t                       vec,
  output logic                                res_valid,
  input  logic                                res_stall,
  output qvr_pkg::res_t                       res,
  input  logic                                cfg_wr_en,
  input  logic [qvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qvr_pkg::ROT_WIDTH-1:0]       cfg_data
);

  `include "assert_macros.svh"

  localparam int VW   = qvr_pkg::VEC_WIDTH;
  localparam int RW   = qvr_pkg::ROT_WIDTH;
  localparam int M1W  = VW + RW;        // one product of stage 1
  localparam int P2W  = M1W + 1;        // sum of three products
  localparam int M3W  = P2W + RW;       // one product of stage 3
  localparam int S4W  = M3W + 2;        // sum of four products

  localparam logic signed [S4W-1:0] SAT_HI = S4W'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [S4W-1:0] SAT_LO = -SAT_HI - S4W'(1);

  // quaternion registers
  logic signed [RW-1:0] qw, qx, qy, qz;

  always_ff @(posedge clk) begin
    if (rst) begin
      qw <= qvr_pkg::ROT_W_RESET;
      qx <= '0;
      qy <= '0;
      qz <= '0;
    end else if (cfg_wr_en) begin
      unique case (qvr_pkg::cfg_reg_t'(cfg_index))
        qvr_pkg::REG_ROT_W: qw <= $signed(cfg_data);
        qvr_pkg::REG_ROT_X: qx <= $signed(cfg_data);
        qvr_pkg::REG_ROT_Y: qy <= $signed(cfg_data);
        qvr_pkg::REG_ROT_Z: qz <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic en1, en2, en3, en4, en5;

  assign en5 = !res_valid || !res_stall;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;
  assign vec_stall = !en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (en1) s1_valid  <= vec_valid;
      if (en2) s2_valid  <= s1_valid;
      if (en3) s3_valid  <= s2_valid;
      if (en4) s4_valid  <= s3_valid;
      if (en5) res_valid <= s4_valid;
    end
  end

  // stage 1: quaternion parts times vector components
  logic signed [M1W-1:0] m1 [12];
  logic signed [VW-1:0]  w1, w2, w3, w4;

  always_ff @(posedge clk) begin
    if (en1) begin
      m1[0]  <= M1W'(qx) * M1W'(vec.vec_x);
      m1[1]  <= M1W'(qy) * M1W'(vec.vec_y);
      m1[2]  <= M1W'(qz) * M1W'(vec.vec_z);
      m1[3]  <= M1W'(qw) * M1W'(vec.vec_x);
      m1[4]  <= M1W'(qy) * M1W'(vec.vec_z);
      m1[5]  <= M1W'(qz) * M1W'(vec.vec_y);
      m1[6]  <= M1W'(qw) * M1W'(vec.vec_y);
      m1[7]  <= M1W'(qx) * M1W'(vec.vec_z);
      m1[8]  <= M1W'(qz) * M1W'(vec.vec_x);
      m1[9]  <= M1W'(qw) * M1W'(vec.vec_z);
      m1[10] <= M1W'(qx) * M1W'(vec.vec_y);
      m1[11] <= M1W'(qy) * M1W'(vec.vec_x);
      w1     <= vec.vec_w;
    end
  end

  // stage 2: p = q * (0, v)
  logic signed [P2W-1:0] p0, p1, p2, p3;

  always_ff @(posedge clk) begin
    if (en2) begin
      p0 <= -P2W'(m1[0]) - P2W'(m1[1]) - P2W'(m1[2]);
      p1 <=  P2W'(m1[3]) + P2W'(m1[4]) - P2W'(m1[5]);
      p2 <=  P2W'(m1[6]) - P2W'(m1[7]) + P2W'(m1[8]);
      p3 <=  P2W'(m1[9]) + P2W'(m1[10]) - P2W'(m1[11]);
      w2 <= w1;
    end
  end

  // stage 3: products of p with the conjugate's coefficients
  logic signed [M3W-1:0] m3 [12];

  always_ff @(posedge clk) begin
    if (en3) begin
      m3[0]  <= M3W'(qx) * M3W'(p0);
      m3[1]  <= M3W'(qw) * M3W'(p1);
      m3[2]  <= M3W'(qz) * M3W'(p2);
      m3[3]  <= M3W'(qy) * M3W'(p3);
      m3[4]  <= M3W'(qy) * M3W'(p0);
      m3[5]  <= M3W'(qz) * M3W'(p1);
      m3[6]  <= M3W'(qw) * M3W'(p2);
      m3[7]  <= M3W'(qx) * M3W'(p3);
      m3[8]  <= M3W'(qz) * M3W'(p0);
      m3[9]  <= M3W'(qy) * M3W'(p1);
      m3[10] <= M3W'(qx) * M3W'(p2);
      m3[11] <= M3W'(qw) * M3W'(p3);
      w3     <= w2;
    end
  end

  // stage 4: full-precision sums, scaled by 2^28
  logic signed [S4W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (en4) begin
      sx <= -S4W'(m3[0]) + S4W'(m3[1]) - S4W'(m3[2])  + S4W'(m3[3]);
      sy <= -S4W'(m3[4]) + S4W'(m3[5]) + S4W'(m3[6])  - S4W'(m3[7]);
      sz <= -S4W'(m3[8]) - S4W'(m3[9]) + S4W'(m3[10]) + S4W'(m3[11]);
      w4 <= w3;
    end
  end

  // stage 5: arithmetic shift floors, then saturate
  function automatic logic signed [VW-1:0] floor_sat(input logic signed [S4W-1:0] s);
    logic signed [S4W-1:0] sh;
    sh = s >>> qvr_pkg::FRAC_SHIFT;
    if (sh > SAT_HI) begin
      floor_sat = SAT_HI[VW-1:0];
    end else if (sh < SAT_LO) begin
      floor_sat = SAT_LO[VW-1:0];
    end else begin
      floor_sat = sh[VW-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en5) begin
      res.out_x <= floor_sat(sx);
      res.out_y <= floor_sat(sy);
      res.out_z <= floor_sat(sz);
      res.out_w <= w4;
    end
  end

  `QVR_ASSERT_ALWAYS(a_reset_empties_output, rst |=> !res_valid)
  `QVR_ASSERT(a_transfer_in_enters_stage1, vec_valid && !vec_stall |=> s1_valid)
  `QVR_ASSERT(a_stall_only_when_full,
    vec_stall |-> s1_valid && s2_valid && s3_valid && s4_valid && res_valid && res_stall)

endmodule
